// ===== sv/mhpq_pkg.sv =====
// Package for the max-heap priority queue.
// Holds sizes, command and status codes, and the sequencer state type.
// No dependencies.
package mhpq_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = ADDR_W + 2;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_LAST_RD,
    S_LAST_LD,
    S_DN_RDL,
    S_DN_RDR,
    S_DN_CMP,
    S_DONE
  } seq_state_t;

endpackage

// ===== sv/mhpq_req_if.sv =====
// Request channel of the max-heap priority queue: valid/ready plus command and value.
// Depends on mhpq_pkg.
interface mhpq_req_if;
  import mhpq_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     command;
  logic signed [DATA_W-1:0] value;

  modport source(output valid, command, value, input ready);
  modport sink(input valid, command, value, output ready);
endinterface

// ===== sv/mhpq_rsp_if.sv =====
// Result channel of the max-heap priority queue: valid/ready plus top, count and status.
// Depends on mhpq_pkg.
interface mhpq_rsp_if;
  import mhpq_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] top_value;
  logic                     top_valid;
  logic [CNT_W-1:0]         entry_count;
  logic [1:0]               status;

  modport source(output valid, top_value, top_valid, entry_count, status, input ready);
  modport sink(input valid, top_value, top_valid, entry_count, status, output ready);
endinterface

// ===== sv/mhpq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/max_heap_priority_queue.sv =====
// Max-heap priority queue: 64 signed 32-bit entries in one RAM, sifted by a small sequencer.
// Push: one read and one compare per level up; a push when full goes straight to the result.
// Pop: two reads and two compares per level down; a pop with one entry or none goes straight to the result.
// One item at a time: req.ready returns as the result loads; a stalled sink holds it.
// Reset (rst, synchronous): heap empty, no result pending; RAM contents are not cleared.
// Depends on mhpq_pkg, mhpq_req_if, mhpq_rsp_if and mhpq_ram.
module max_heap_priority_queue (
  input logic       clk,
  input logic       rst,
  mhpq_req_if.sink  req,
  mhpq_rsp_if.source rsp
);
  import mhpq_pkg::*;

  seq_state_t state, state_next;

  logic [CNT_W-1:0]         cnt, cnt_next;
  logic [ADDR_W-1:0]        idx, idx_next;
  logic signed [DATA_W-1:0] cur, cur_next;
  logic signed [DATA_W-1:0] best, best_next;
  logic                     took_l, took_l_next;
  logic [1:0]               status, status_next;
  logic signed [DATA_W-1:0] root;

  logic                     out_valid;
  logic signed [DATA_W-1:0] out_top;
  logic                     out_top_valid;
  logic [CNT_W-1:0]         out_count;
  logic [1:0]               out_status;

  logic                     we;
  logic [ADDR_W-1:0]        waddr, raddr;
  logic signed [DATA_W-1:0] wdata, rdata;

  logic [IDX_W-1:0] left_idx, right_idx, cnt_ext;
  logic             left_ok, right_ok, right_big, out_free;

  mhpq_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign cnt_ext   = IDX_W'(cnt);
  assign left_idx  = (IDX_W'(idx) << 1) + IDX_W'(1);
  assign right_idx = (IDX_W'(idx) << 1) + IDX_W'(2);
  assign left_ok   = left_idx < cnt_ext;
  assign right_ok  = right_idx < cnt_ext;
  assign right_big = right_ok && (rdata > best);
  assign out_free  = !out_valid || rsp.ready;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          if (req.command == CMD_PUSH) begin
            state_next = (cnt == CNT_W'(CAPACITY)) ? S_DONE : S_UP_RD;
          end else if (cnt <= CNT_W'(1)) begin
            state_next = S_DONE;
          end else begin
            state_next = S_LAST_RD;
          end
        end
      end
      S_UP_RD:   state_next = (idx == '0) ? S_DONE : S_UP_CMP;
      S_UP_CMP:  state_next = (rdata >= cur) ? S_DONE : S_UP_RD;
      S_LAST_RD: state_next = S_LAST_LD;
      S_LAST_LD: state_next = S_DN_RDL;
      S_DN_RDL:  state_next = left_ok ? S_DN_RDR : S_DONE;
      S_DN_RDR:  state_next = S_DN_CMP;
      S_DN_CMP:  state_next = (right_big || took_l) ? S_DN_RDL : S_DONE;
      S_DONE:    state_next = out_free ? S_IDLE : S_DONE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    we          = 1'b0;
    waddr       = idx;
    wdata       = cur;
    raddr       = '0;
    cnt_next    = cnt;
    idx_next    = idx;
    cur_next    = cur;
    best_next   = best;
    took_l_next = took_l;
    status_next = status;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          status_next = ST_OK;
          if (req.command == CMD_PUSH) begin
            if (cnt == CNT_W'(CAPACITY)) begin
              status_next = ST_FULL;
            end else begin
              idx_next = cnt[ADDR_W-1:0];
              cur_next = req.value;
              cnt_next = cnt + CNT_W'(1);
            end
          end else if (cnt == '0) begin
            status_next = ST_EMPTY;
          end else begin
            idx_next = '0;
            cnt_next = cnt - CNT_W'(1);
          end
        end
      end
      S_UP_RD: begin
        if (idx == '0) begin
          we = 1'b1;
        end else begin
          raddr = (idx - ADDR_W'(1)) >> 1;
        end
      end
      S_UP_CMP: begin
        we = 1'b1;
        if (rdata < cur) begin
          wdata    = rdata;
          idx_next = (idx - ADDR_W'(1)) >> 1;
        end
      end
      S_LAST_RD: raddr = cnt[ADDR_W-1:0];
      S_LAST_LD: cur_next = rdata;
      S_DN_RDL: begin
        if (left_ok) begin
          raddr = left_idx[ADDR_W-1:0];
        end else begin
          we = 1'b1;
        end
      end
      S_DN_RDR: begin
        raddr       = right_idx[ADDR_W-1:0];
        took_l_next = rdata > cur;
        best_next   = (rdata > cur) ? rdata : cur;
      end
      S_DN_CMP: begin
        we = 1'b1;
        if (right_big) begin
          wdata    = rdata;
          idx_next = right_idx[ADDR_W-1:0];
        end else if (took_l) begin
          wdata    = best;
          idx_next = left_idx[ADDR_W-1:0];
        end
      end
      S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx    <= idx_next;
    cur    <= cur_next;
    best   <= best_next;
    took_l <= took_l_next;
    status <= status_next;
    if (we && waddr == '0) begin
      root <= wdata;
    end
    if (state == S_DONE && out_free) begin
      out_top       <= (cnt != '0) ? root : '0;
      out_top_valid <= cnt != '0;
      out_count     <= cnt;
      out_status    <= status;
    end
  end

  assign req.ready       = state == S_IDLE;
  assign rsp.valid       = out_valid;
  assign rsp.top_value   = out_top;
  assign rsp.top_valid   = out_top_valid;
  assign rsp.entry_count = out_count;
  assign rsp.status      = out_status;

endmodule

// ===== verif/tb.sv =====
// Testbench for max_heap_priority_queue: drives push and pop items, predicts each result
// with a behavioral heap of its own and checks every result field by field.
// Depends on mhpq_pkg, mhpq_req_if, mhpq_rsp_if and the max_heap_priority_queue RTL.
module tb;
  import mhpq_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 800;
  localparam int QUIET_TAIL   = 80;

  localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct {
    logic                     command;
    logic signed [DATA_W-1:0] value;
  } heap_op_t;

  typedef struct {
    logic signed [DATA_W-1:0] top_value;
    logic                     top_valid;
    logic [CNT_W-1:0]         entry_count;
    logic [1:0]               status;
  } heap_view_t;

  logic clk;
  logic rst;

  mhpq_req_if req_ch ();
  mhpq_rsp_if rsp_ch ();

  max_heap_priority_queue i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  heap_op_t   pending_ops[$];
  heap_view_t top_expected[$];

  logic signed [DATA_W-1:0] heap_img[CAPACITY];
  int img_fill;

  int errors;
  int cycles;
  int items_sent;
  int results_seen;
  int src_gap;
  int snk_gap;
  int src_idle_pct;
  int snk_idle_pct;
  int pushes_ok;
  int pushes_full;
  int pops_ok;
  int pops_empty;
  int peak_fill;
  heap_op_t   next_op;
  heap_view_t next_view;
  heap_view_t got_view;
  heap_view_t want_view;

  function automatic heap_view_t heap_apply(logic cmd, logic signed [DATA_W-1:0] val);
    heap_view_t r;
    logic signed [DATA_W-1:0] t;
    int i;
    int p;
    int l;
    int rc;
    int big;
    bit done;
    r.status = ST_OK;
    if (cmd == CMD_PUSH) begin
      if (img_fill >= CAPACITY) begin
        r.status = ST_FULL;
        pushes_full++;
      end else begin
        i = img_fill;
        heap_img[i] = val;
        img_fill++;
        pushes_ok++;
        done = 1'b0;
        while (i > 0 && !done) begin
          p = (i - 1) / 2;
          if (heap_img[p] >= heap_img[i]) begin
            done = 1'b1;
          end else begin
            t = heap_img[p];
            heap_img[p] = heap_img[i];
            heap_img[i] = t;
            i = p;
          end
        end
      end
    end else begin
      if (img_fill == 0) begin
        r.status = ST_EMPTY;
        pops_empty++;
      end else begin
        img_fill--;
        pops_ok++;
        heap_img[0] = heap_img[img_fill];
        i = 0;
        done = 1'b0;
        while (!done) begin
          l = 2 * i + 1;
          rc = 2 * i + 2;
          big = i;
          if (l < img_fill && heap_img[l] > heap_img[big]) big = l;
          if (rc < img_fill && heap_img[rc] > heap_img[big]) big = rc;
          if (big == i) begin
            done = 1'b1;
          end else begin
            t = heap_img[i];
            heap_img[i] = heap_img[big];
            heap_img[big] = t;
            i = big;
          end
        end
      end
    end
    if (img_fill > peak_fill) peak_fill = img_fill;
    r.top_valid   = (img_fill > 0);
    r.top_value   = (img_fill > 0) ? heap_img[0] : '0;
    r.entry_count = CNT_W'(img_fill);
    return r;
  endfunction

  function automatic void check_field(string fname, logic [DATA_W-1:0] want,
                                      logic [DATA_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
      errors++;
    end
  endfunction

  task automatic queue_op(logic cmd, logic signed [DATA_W-1:0] val);
    heap_op_t op;
    op.command = cmd;
    op.value   = val;
    pending_ops = {pending_ops, op};
  endtask

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        next_view = heap_apply(req_ch.command, req_ch.value);
        top_expected = {top_expected, next_view};
        items_sent++;
        if (items_sent % 64 == 0) src_idle_pct = $urandom_range(0, 3) * 20;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          req_ch.valid <= 1'b0;
        end else if (pending_ops.size() == 0) begin
          req_ch.valid <= 1'b0;
        end else if (pending_ops.size() > QUIET_TAIL &&
                     $urandom_range(0, 99) < src_idle_pct) begin
          src_gap = $urandom_range(1, 12) - 1;
          req_ch.valid <= 1'b0;
        end else begin
          next_op = pending_ops.pop_front();
          req_ch.valid   <= 1'b1;
          req_ch.command <= next_op.command;
          req_ch.value   <= next_op.value;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        results_seen++;
        if (results_seen % 64 == 0) snk_idle_pct = $urandom_range(0, 3) * 20;
        got_view.top_value   = rsp_ch.top_value;
        got_view.top_valid   = rsp_ch.top_valid;
        got_view.entry_count = rsp_ch.entry_count;
        got_view.status      = rsp_ch.status;
        if (top_expected.size() == 0) begin
          $display("%0t: unexpected result, actual top %h valid %b count %0d status %0d",
                   $time, got_view.top_value, got_view.top_valid, got_view.entry_count,
                   got_view.status);
          errors++;
        end else begin
          want_view = top_expected.pop_front();
          check_field("top_value", want_view.top_value, got_view.top_value);
          check_field("top_valid", DATA_W'(want_view.top_valid), DATA_W'(got_view.top_valid));
          check_field("entry_count", DATA_W'(want_view.entry_count),
                      DATA_W'(got_view.entry_count));
          check_field("status", DATA_W'(want_view.status), DATA_W'(got_view.status));
        end
      end
      if (snk_gap > 0) begin
        snk_gap--;
        rsp_ch.ready <= 1'b0;
      end else if (pending_ops.size() > QUIET_TAIL &&
                   $urandom_range(0, 99) < snk_idle_pct) begin
        snk_gap = $urandom_range(1, 12) - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int n;
    int phase;
    int phase_len;
    int push_pct;
    logic signed [DATA_W-1:0] v;
    clk = 1'b0;
    rst = 1'b1;
    req_ch.valid   = 1'b0;
    req_ch.command = CMD_PUSH;
    req_ch.value   = '0;
    rsp_ch.ready   = 1'b0;
    errors = 0;
    cycles = 0;
    items_sent = 0;
    results_seen = 0;
    src_gap = 0;
    snk_gap = 0;
    src_idle_pct = 20;
    snk_idle_pct = 20;
    pushes_ok = 0;
    pushes_full = 0;
    pops_ok = 0;
    pops_empty = 0;
    peak_fill = 0;
    img_fill = 0;

    queue_op(CMD_POP, VAL_MAX);
    queue_op(CMD_PUSH, '0);
    queue_op(CMD_PUSH, VAL_MAX);
    queue_op(CMD_PUSH, VAL_MIN);
    queue_op(CMD_PUSH, -1);
    queue_op(CMD_PUSH, 1);
    queue_op(CMD_PUSH, VAL_MAX);
    queue_op(CMD_PUSH, -1);
    repeat (7) queue_op(CMD_POP, VAL_MIN);
    queue_op(CMD_POP, '0);
    repeat (3) queue_op(CMD_PUSH, 5);
    queue_op(CMD_POP, -1);
    queue_op(CMD_PUSH, VAL_MIN + 1);
    repeat (4) queue_op(CMD_POP, '1);

    // cycle through fill, churn and drain phases so the heap hits full and empty often
    n = 0;
    phase = 0;
    while (n < RANDOM_ITEMS) begin
      case (phase % 3)
        0: begin
          push_pct = 90;
          phase_len = $urandom_range(80, 110);
        end
        1: begin
          push_pct = 50;
          phase_len = $urandom_range(40, 90);
        end
        default: begin
          push_pct = 10;
          phase_len = $urandom_range(80, 110);
        end
      endcase
      repeat (phase_len) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: v = $urandom;
          4, 5, 6:    v = $signed($urandom_range(0, 8)) - 4;
          7:          v = VAL_MAX - $urandom_range(0, 2);
          8:          v = VAL_MIN + $urandom_range(0, 2);
          default:    v = $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
        endcase
        queue_op(($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP, v);
        n++;
      end
      phase++;
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (pending_ops.size() > 0 || req_ch.valid) @(posedge clk);
    while (top_expected.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("ran %0d items, %0d results: %0d pushes kept, %0d dropped on full",
             items_sent, results_seen, pushes_ok, pushes_full);
    $display("%0d pops taken, %0d on empty, peak fill %0d of %0d",
             pops_ok, pops_empty, peak_fill, CAPACITY);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/mhpq_pkg.sv
sv/mhpq_req_if.sv
sv/mhpq_rsp_if.sv
sv/mhpq_ram.sv
sv/max_heap_priority_queue.sv
verif/tb.sv
